### rtl/base64_stream_codec_unit_assert.svh
// Assertion macros for the base64 stream codec.
// Used by base64_stream_codec_unit.sv; no other dependencies.
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define B64SC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("b64sc: forbidden condition seen");
`define B64SC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64sc: expected condition missing");
`else
`define B64SC_ASSERT_NEVER(label, clk, rst_n, expr)
`define B64SC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/b64sc_pkg.sv
// Types, character codes and alphabet functions for the base64 stream codec.
// No dependencies; imported by the top level.
package b64sc_pkg;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       no_data;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26)      r = CharUpA + {2'b00, v};
    else if (v < 6'd52) r = CharLowA + {2'b00, v} - 8'd26;
    else if (v < 6'd62) r = CharZero + {2'b00, v} - 8'd52;
    else if (v == 6'd62) r = CharPlus;
    else                r = CharSlash;
    return r;
  endfunction

  // alphabet character to 6-bit value; ok is low outside the alphabet
  function automatic sym_t sym_value(input logic [7:0] c);
    sym_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= CharUpA && c <= CharUpZ)        r.val = 6'(c - CharUpA);
    else if (c >= CharLowA && c <= CharLowZ) r.val = 6'(c - CharLowA + 8'd26);
    else if (c >= CharZero && c <= CharNine) r.val = 6'(c - CharZero + 8'd52);
    else if (c == CharPlus)                  r.val = 6'd62;
    else if (c == CharSlash)                 r.val = 6'd63;
    else                                     r.ok  = 1'b0;
    return r;
  endfunction

endpackage

### rtl/b64sc_if.sv
// Valid/ready stream interfaces for the base64 stream codec.
// No dependencies.
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       no_data;

  modport source (output valid, output out_byte, output out_last, output no_data,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input no_data,
                  output ready);
endinterface

### rtl/base64_stream_codec_unit.sv
// Base64 encode/decode over a byte stream; direction set by the mode bit written via cfg_we_i/cfg_wdata_i.
// Results are registered: a result shows on the output the cycle after its input beat is taken.
// A beat yields 0 to 4 results, sent one per cycle while the output is ready; the next
// beat is taken in the cycle the last one leaves, so a beat that yields results holds
// the input until all of its results have left.
// Reset (async, active low) empties the buffer, clears group state, selects encode.
`include "base64_stream_codec_unit_assert.svh"

module base64_stream_codec_unit
  import b64sc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  b64sc_in_if.sink    in_i,
  b64sc_out_if.source out_o
);

  logic        mode_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  gcnt_q, gcnt_d;
  logic        pad_q, pad_d;

  res_t        res_q [MaxResults];
  res_t        res_d [MaxResults];
  res_t        calc  [MaxResults];
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  nres;

  logic in_acc, pop;
  logic [23:0] enc_sh, dec_sh;
  logic [1:0]  enc_cnt;
  sym_t        sym;

  assign out_o.valid    = (cnt_q != 3'd0);
  assign out_o.out_byte = res_q[0].out_byte;
  assign out_o.out_last = res_q[0].out_last;
  assign out_o.no_data  = res_q[0].no_data;

  assign pop      = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_o.ready);
  assign in_acc   = in_i.valid && in_i.ready;

  assign enc_sh  = {bits_q[15:0], in_i.in_byte};
  assign enc_cnt = gcnt_q + 2'd1;
  assign sym     = sym_value(in_i.in_byte);
  assign dec_sh  = {bits_q[17:0], sym.val};

  // results and next group state for the beat on the input
  always_comb begin
    for (int k = 0; k < MaxResults; k++) calc[k] = '0;
    nres   = 3'd0;
    bits_d = bits_q;
    gcnt_d = gcnt_q;
    pad_d  = pad_q;
    if (!mode_q) begin
      bits_d = enc_sh;
      gcnt_d = enc_cnt;
      if (enc_cnt == 2'd3) begin
        calc[0].out_byte = sym_char(enc_sh[23:18]);
        calc[1].out_byte = sym_char(enc_sh[17:12]);
        calc[2].out_byte = sym_char(enc_sh[11:6]);
        calc[3].out_byte = sym_char(enc_sh[5:0]);
        nres   = 3'd4;
        bits_d = '0;
        gcnt_d = 2'd0;
      end else if (in_i.end_of_stream && enc_cnt == 2'd1) begin
        calc[0].out_byte = sym_char(enc_sh[7:2]);
        calc[1].out_byte = sym_char({enc_sh[1:0], 4'b0000});
        calc[2].out_byte = CharPad;
        calc[3].out_byte = CharPad;
        nres = 3'd4;
      end else if (in_i.end_of_stream && enc_cnt == 2'd2) begin
        calc[0].out_byte = sym_char(enc_sh[15:10]);
        calc[1].out_byte = sym_char(enc_sh[9:4]);
        calc[2].out_byte = sym_char({enc_sh[3:0], 2'b00});
        calc[3].out_byte = CharPad;
        nres = 3'd4;
      end
    end else if (!pad_q) begin
      if (in_i.in_byte == CharPad) begin
        if (gcnt_q == 2'd2) begin
          calc[0].out_byte = bits_q[11:4];
          nres = 3'd1;
        end else if (gcnt_q == 2'd3) begin
          calc[0].out_byte = bits_q[17:10];
          calc[1].out_byte = bits_q[9:2];
          nres = 3'd2;
        end
        bits_d = '0;
        gcnt_d = 2'd0;
        pad_d  = 1'b1;
      end else if (sym.ok) begin
        if (gcnt_q == 2'd3) begin
          calc[0].out_byte = dec_sh[23:16];
          calc[1].out_byte = dec_sh[15:8];
          calc[2].out_byte = dec_sh[7:0];
          nres   = 3'd3;
          bits_d = '0;
          gcnt_d = 2'd0;
        end else begin
          bits_d = dec_sh;
          gcnt_d = gcnt_q + 2'd1;
        end
      end
    end
    if (in_i.end_of_stream) begin
      if (nres == 3'd0) begin
        calc[0].no_data = 1'b1;
        nres = 3'd1;
      end
      for (int k = 0; k < MaxResults; k++) begin
        if (nres == 3'(k + 1)) calc[k].out_last = 1'b1;
      end
      bits_d = '0;
      gcnt_d = 2'd0;
      pad_d  = 1'b0;
    end
  end

  // result buffer: head is always entry 0, shifted on each output beat
  always_comb begin
    for (int k = 0; k < MaxResults; k++) res_d[k] = res_q[k];
    cnt_d = cnt_q;
    if (pop) begin
      for (int k = 0; k < MaxResults - 1; k++) res_d[k] = res_q[k + 1];
      cnt_d = cnt_q - 3'd1;
    end
    if (in_acc) begin
      for (int k = 0; k < MaxResults; k++) res_d[k] = calc[k];
      cnt_d = nres;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) res_q[k] <= res_d[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bits_q <= '0;
      gcnt_q <= '0;
      pad_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
        bits_q <= '0;
        gcnt_q <= '0;
        pad_q  <= 1'b0;
      end else if (in_acc) begin
        bits_q <= bits_d;
        gcnt_q <= gcnt_d;
        pad_q  <= pad_d;
      end
    end
  end

  `B64SC_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > 3'd4)
  `B64SC_ASSERT_NEVER(a_nodata_alone, clk_i, rst_ni, out_o.valid && out_o.no_data && !(out_o.out_last && cnt_q == 3'd1))
  `B64SC_ASSERT_IMPLIES(a_eos_result, clk_i, rst_ni, in_acc && in_i.end_of_stream, cnt_q != 3'd0)
  `B64SC_ASSERT_IMPLIES(a_eos_clear, clk_i, rst_ni, in_acc && in_i.end_of_stream, gcnt_q == 2'd0 && !pad_q)

endmodule
